// ===== rtl/lpd_pkg.sv =====
// Shared types and constants of the length-prefixed deframer.
// No dependencies; used by every module of the block.
package lpd_pkg;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HCNT_W = 3;

  localparam logic [HCNT_W-1:0] HDR_BYTES      = 3'd4;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 32'd512000;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_TOO_LONG = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic               is_last;
    logic [LEN_W-1:0]   message_length;
  } result_t;

endpackage

// ===== rtl/lpd_in_reg.sv =====
// Input register of the deframer: holds one stream byte until the parser takes it.
// Depends on lpd_pkg.
module lpd_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lpd_pkg::BYTE_W-1:0] in_stream_byte,
  input  logic                      take,
  output logic                      byte_valid,
  output logic [lpd_pkg::BYTE_W-1:0] byte_data
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [lpd_pkg::BYTE_W-1:0] byte_r;

  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_stream_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// ===== rtl/lpd_parse.sv =====
// Header/payload parser: length assembly, limit check and payload counting.
// Holds max_length. Depends on lpd_pkg.
module lpd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        step,
  input  logic [lpd_pkg::BYTE_W-1:0]  byte_data,
  output logic                        res_valid,
  output lpd_pkg::result_t            res,
  output logic [lpd_pkg::LEN_W-1:0]   max_length
);

  logic [lpd_pkg::LEN_W-1:0]  max_length_r;
  logic [lpd_pkg::HCNT_W-1:0] header_count_r;
  logic [lpd_pkg::HCNT_W-1:0] header_count_nxt;
  logic [lpd_pkg::LEN_W-1:0]  length_r;
  logic [lpd_pkg::LEN_W-1:0]  length_nxt;
  logic [lpd_pkg::LEN_W-1:0]  payload_count_r;
  logic [lpd_pkg::LEN_W-1:0]  payload_count_nxt;
  logic [lpd_pkg::LEN_W-1:0]  len_shift;
  logic [lpd_pkg::LEN_W-1:0]  pcnt_inc;
  logic [lpd_pkg::HCNT_W-1:0] hcnt_inc;

  assign len_shift = {length_r[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], byte_data};
  assign pcnt_inc  = payload_count_r + lpd_pkg::LEN_W'(1);
  assign hcnt_inc  = header_count_r + lpd_pkg::HCNT_W'(1);

  always_comb begin
    header_count_nxt   = header_count_r;
    length_nxt         = length_r;
    payload_count_nxt  = payload_count_r;
    res_valid          = 1'b0;
    res.kind           = lpd_pkg::KIND_PAYLOAD;
    res.payload_byte   = '0;
    res.is_last        = 1'b1;
    res.message_length = length_r;
    if (header_count_r < lpd_pkg::HDR_BYTES) begin
      length_nxt       = len_shift;
      header_count_nxt = hcnt_inc;
      if (hcnt_inc == lpd_pkg::HDR_BYTES) begin
        payload_count_nxt  = '0;
        res.message_length = len_shift;
        if (len_shift > max_length_r) begin
          res_valid        = 1'b1;
          res.kind         = lpd_pkg::KIND_TOO_LONG;
          header_count_nxt = '0;
        end else if (len_shift == '0) begin
          res_valid        = 1'b1;
          res.kind         = lpd_pkg::KIND_EMPTY;
          header_count_nxt = '0;
        end
      end
    end else begin
      res_valid        = 1'b1;
      res.kind         = lpd_pkg::KIND_PAYLOAD;
      res.payload_byte = byte_data;
      res.is_last      = (pcnt_inc >= length_r);
      if (pcnt_inc >= length_r) begin
        header_count_nxt  = '0;
        payload_count_nxt = '0;
      end else begin
        header_count_nxt  = lpd_pkg::HDR_BYTES;
        payload_count_nxt = pcnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= lpd_pkg::MAX_LEN_RESET;
      header_count_r  <= '0;
      length_r        <= '0;
      payload_count_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_length_r <= cfg_wr_data;
      end
      if (step) begin
        header_count_r  <= header_count_nxt;
        length_r        <= length_nxt;
        payload_count_r <= payload_count_nxt;
      end
    end
  end

  assign max_length = max_length_r;

endmodule

// ===== rtl/lpd_out_reg.sv =====
// Result register of the deframer; loads whenever it is empty or being drained.
// Depends on lpd_pkg.
module lpd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             res_valid,
  input  lpd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output lpd_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  lpd_pkg::result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = free ? (step && res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/length_prefixed_deframer_core.sv =====
// Channel   Handshake            Payload
// in        in_valid/in_stall    in_stream_byte[7:0]
// out       out_valid/out_stall  out_kind, out_payload_byte, out_is_last, out_message_length
// cfg       cfg_wr_en            cfg_wr_data[31:0] -> max_length
//
// One byte per cycle sustained while out_stall is low; a result is loaded into the result
// register at the same edge that drains its byte from the input register.
// rst_n is synchronous; max_length resets to 512000, counters to zero.
// in_stall rises only while the input register is full and the result register is held.
// Top level of the length-prefixed deframer; depends on lpd_pkg, lpd_in_reg,
// lpd_parse and lpd_out_reg.
module length_prefixed_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_last,
  output logic [31:0] out_message_length
);

  logic                        take;
  logic                        byte_valid;
  logic [lpd_pkg::BYTE_W-1:0]  byte_data;
  logic                        step;
  logic                        res_valid;
  lpd_pkg::result_t            res;
  lpd_pkg::result_t            out_res;
  logic [lpd_pkg::LEN_W-1:0]   max_length;

  assign step = byte_valid && take;

  lpd_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .take           (take),
    .byte_valid     (byte_valid),
    .byte_data      (byte_data)
  );

  lpd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .byte_data   (byte_data),
    .res_valid   (res_valid),
    .res         (res),
    .max_length  (max_length)
  );

  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .free      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_is_last        = out_res.is_last;
  assign out_message_length = out_res.message_length;

`ifndef SYNTHESIS
  a_ctl_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.kind != lpd_pkg::KIND_PAYLOAD) |-> out_res.is_last)
    else $error("control result without is_last");

  a_ctl_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.kind != lpd_pkg::KIND_PAYLOAD) |-> (out_res.payload_byte == '0))
    else $error("control result carries payload byte");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.kind == lpd_pkg::KIND_EMPTY) |-> (out_res.message_length == '0))
    else $error("empty message with nonzero length");

  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.kind == lpd_pkg::KIND_TOO_LONG)
      |-> (out_res.message_length > max_length))
    else $error("too-long error for length within limit");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("held result lost or changed");
`endif

endmodule
